// ----- rtl/tip_pkg.sv -----
// Shared types and constants for the tagged interval profiler.
// Holds the item structs, the slot record layout, event kinds and status codes.
// No dependencies.
package tip_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int TAG_BITS = 16;
    localparam int TS_W     = 48;
    localparam int DVD_W    = 68;
    localparam int DIVC_W   = 7;

    localparam logic [TS_W-1:0] M48        = {TS_W{1'b1}};
    localparam logic [19:0]     US_PER_S   = 20'd1000000;
    localparam logic [31:0]     TRIM_LIMIT = 32'd4;
    localparam logic [31:0]     FREQ_RESET = 32'd10000000;
    localparam logic [31:0]     COUNT_MAX  = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_BEGIN_TWICE = 3'd2;
    localparam logic [2:0] ST_UNKNOWN     = 3'd3;
    localparam logic [2:0] ST_NO_BEGIN    = 3'd4;
    localparam logic [2:0] ST_NO_CALLS    = 3'd5;

    typedef struct packed {
        logic [1:0]      kind;
        logic [15:0]     tag;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [2:0]      status;
        logic [TS_W-1:0] elapsed_us;
        logic [31:0]     call_count;
        logic [TS_W-1:0] total_us;
        logic [TS_W-1:0] min_us;
        logic [TS_W-1:0] second_min_us;
        logic [TS_W-1:0] max_us;
        logic [TS_W-1:0] second_max_us;
        logic [TS_W-1:0] average_us;
        logic            running;
    } t_out_item;

    typedef struct packed {
        logic [TS_W-1:0] start;
        logic [TS_W-1:0] total;
        logic [31:0]     count;
        logic [TS_W-1:0] min0;
        logic [TS_W-1:0] min1;
        logic [TS_W-1:0] max0;
        logic [TS_W-1:0] max1;
    } t_rec;

endpackage

// ----- rtl/tagged_interval_profiler_top.sv -----
// A tag scan over the slots in use (one slot a cycle) ends in a miss (begin allocate, full,
// unknown) or a hit. An end runs a 68-step tick divide, and a hit with completed calls a
// 48-step average divide, both on one shared restoring divider, one bit a cycle.
// Throughput: one item at a time; the next item is taken while the result waits.
// Reset (synchronous, active low) empties the table, clears running bits and output valid,
// and loads the counter frequency with 10000000. No clearing pass.
// Depends on tip_pkg.
module tagged_interval_profiler_top
    import tip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SRCH = 13'b0000000000010,
        S_DISP = 13'b0000000000100,
        S_EVAL = 13'b0000000001000,
        S_MUL  = 13'b0000000010000,
        S_ADD  = 13'b0000000100000,
        S_DIV  = 13'b0000001000000,
        S_UPD  = 13'b0000010000000,
        S_CUT  = 13'b0000100000000,
        S_TRIM = 13'b0001000000000,
        S_EMIT = 13'b0010000000000,
        S_RSV0 = 13'b0100000000000,
        S_RSV1 = 13'b1000000000000
    } t_state;

    logic [TAG_BITS-1:0] mem_tag [SLOTS];
    t_rec                mem_rec [SLOTS];

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [SLOTS-1:0]    r_run, n_run;
    logic [31:0]         r_freq;
    logic                r_out_v, n_out_v;
    t_out_item           r_out, n_out;

    t_in_item            r_in, n_in;
    logic                r_found, n_found;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_scan, n_scan;
    logic                r_scan_v, n_scan_v;
    logic [SLOT_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [TAG_BITS-1:0] r_tag_q;
    t_rec                r_rec_q;
    t_rec                r_rec, n_rec;
    logic [2:0]          r_status, n_status;
    logic                r_empty, n_empty;
    logic [TS_W-1:0]     r_elapsed, n_elapsed;
    logic [TS_W-1:0]     r_avg, n_avg;
    logic [TS_W-1:0]     r_ticks, n_ticks;
    logic [43:0]         r_p_lo, n_p_lo;
    logic [43:0]         r_p_hi, n_p_hi;
    logic [49:0]         r_cut, n_cut;
    logic [DVD_W-1:0]    r_dvd, n_dvd;
    logic [31:0]         r_dvs, n_dvs;
    logic [31:0]         r_rem, n_rem;
    logic [DVD_W-1:0]    r_quo, n_quo;
    logic [DIVC_W-1:0]   r_div_cnt, n_div_cnt;
    logic                r_div_avg, n_div_avg;

    logic                w_tag_we;
    logic [SLOT_W-1:0]   w_tag_wa;
    logic                w_rec_we;
    logic [SLOT_W-1:0]   w_rec_wa;
    t_rec                w_rec_wd;
    logic [SLOT_W-1:0]   w_scan_a;

    logic [32:0]         w_rem_sh, w_rem_diff;
    logic                w_ge;
    logic [DVD_W-1:0]    w_quo_nx;
    logic [48:0]         w_tsum;
    logic [48:0]         w_trim;
    t_rec                w_fresh, w_upd;
    logic                w_hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign w_scan_a    = r_scan[SLOT_W-1:0];

    // one divider step: restoring, one quotient bit a cycle
    assign w_rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_dvs};
    assign w_ge       = (w_rem_sh >= {1'b0, r_dvs});
    assign w_quo_nx   = {r_quo[DVD_W-2:0], w_ge};

    assign w_hit = r_scan_v && (r_tag_q == r_in.tag[TAG_BITS-1:0]);

    always_comb begin
        w_fresh       = '0;
        w_fresh.start = r_in.timestamp;
        w_fresh.min0  = M48;
        w_fresh.min1  = M48;

        w_upd  = r_rec;
        w_tsum = {1'b0, r_rec.total} + {1'b0, r_elapsed};
        w_upd.total = w_tsum[TS_W] ? M48 : w_tsum[TS_W-1:0];
        w_upd.count = (r_rec.count == COUNT_MAX) ? r_rec.count : r_rec.count + 32'd1;
        if (r_elapsed < r_rec.min0) begin
            w_upd.min1 = r_rec.min0;
            w_upd.min0 = r_elapsed;
        end else if (r_elapsed < r_rec.min1) begin
            w_upd.min1 = r_elapsed;
        end
        if (r_elapsed > r_rec.max0) begin
            w_upd.max1 = r_rec.max0;
            w_upd.max0 = r_elapsed;
        end else if (r_elapsed > r_rec.max1) begin
            w_upd.max1 = r_elapsed;
        end

        w_trim = ({2'b0, r_rec.total} > r_cut) ? 49'({2'b0, r_rec.total} - r_cut) : 49'd0;
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_run     = r_run;
        n_out_v   = r_out_v;
        n_out     = r_out;
        n_in      = r_in;
        n_found   = r_found;
        n_slot    = r_slot;
        n_scan    = r_scan;
        n_scan_v  = r_scan_v;
        n_cmp_idx = r_cmp_idx;
        n_rec     = r_rec;
        n_status  = r_status;
        n_empty   = r_empty;
        n_elapsed = r_elapsed;
        n_avg     = r_avg;
        n_ticks   = r_ticks;
        n_p_lo    = r_p_lo;
        n_p_hi    = r_p_hi;
        n_cut     = r_cut;
        n_dvd     = r_dvd;
        n_dvs     = r_dvs;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_div_cnt = r_div_cnt;
        n_div_avg = r_div_avg;
        w_tag_we  = 1'b0;
        w_tag_wa  = r_used[SLOT_W-1:0];
        w_rec_we  = 1'b0;
        w_rec_wa  = r_slot;
        w_rec_wd  = w_fresh;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in      = i_in_data;
                    n_elapsed = '0;
                    n_avg     = '0;
                    n_empty   = 1'b0;
                    n_status  = ST_OK;
                    if (i_in_data.kind == KIND_CLEAR) begin
                        n_run   = '0;
                        n_used  = '0;
                        n_empty = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_scan   = '0;
                        n_scan_v = 1'b0;
                        n_state  = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                // compare the entry read last cycle while the next read goes out
                if (w_hit) begin
                    n_found = 1'b1;
                    n_slot  = r_cmp_idx;
                    n_state = S_DISP;
                end else if (r_scan < r_used) begin
                    n_cmp_idx = w_scan_a;
                    n_scan_v  = 1'b1;
                    n_scan    = r_scan + CNT_W'(1);
                end else begin
                    n_found = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_found) begin
                    n_state = S_EVAL;
                end else if (r_in.kind == KIND_BEGIN) begin
                    if (r_used == CNT_W'(SLOTS)) begin
                        n_empty  = 1'b1;
                        n_status = ST_FULL;
                    end else begin
                        w_tag_we = 1'b1;
                        w_rec_we = 1'b1;
                        w_rec_wa = r_used[SLOT_W-1:0];
                        n_slot   = r_used[SLOT_W-1:0];
                        n_rec    = w_fresh;
                        n_run[r_used[SLOT_W-1:0]] = 1'b1;
                        n_used   = r_used + CNT_W'(1);
                    end
                    n_state = S_EMIT;
                end else begin
                    n_empty  = 1'b1;
                    n_status = ST_UNKNOWN;
                    n_state  = S_EMIT;
                end
            end
            S_EVAL: begin
                n_rec = r_rec_q;
                n_state = S_CUT;
                unique case (r_in.kind)
                    KIND_BEGIN: begin
                        if (r_run[r_slot]) begin
                            n_status = ST_BEGIN_TWICE;
                        end else begin
                            n_rec.start  = r_in.timestamp;
                            w_rec_we     = 1'b1;
                            w_rec_wd     = r_rec_q;
                            w_rec_wd.start = r_in.timestamp;
                            n_run[r_slot] = 1'b1;
                        end
                    end
                    KIND_END: begin
                        if (!r_run[r_slot]) begin
                            n_status = ST_NO_BEGIN;
                        end else begin
                            n_ticks = r_in.timestamp - r_rec_q.start;
                            n_state = S_MUL;
                        end
                    end
                    default: begin
                        n_status = (r_rec_q.count == 32'd0) ? ST_NO_CALLS : ST_OK;
                    end
                endcase
            end
            S_MUL: begin
                n_p_lo  = 44'(r_ticks[23:0]) * 44'(US_PER_S);
                n_p_hi  = 44'(r_ticks[47:24]) * 44'(US_PER_S);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_dvd     = (DVD_W'(r_p_hi) << 24) + DVD_W'(r_p_lo);
                n_dvs     = (r_freq == 32'd0) ? 32'd1 : r_freq;
                n_rem     = '0;
                n_quo     = '0;
                n_div_cnt = DIVC_W'(DVD_W);
                n_div_avg = 1'b0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                n_rem     = w_ge ? w_rem_diff[31:0] : w_rem_sh[31:0];
                n_dvd     = {r_dvd[DVD_W-2:0], 1'b0};
                n_quo     = w_quo_nx;
                n_div_cnt = r_div_cnt - DIVC_W'(1);
                if (r_div_cnt == DIVC_W'(1)) begin
                    if (r_div_avg) begin
                        n_avg   = w_quo_nx[TS_W-1:0];
                        n_state = S_EMIT;
                    end else begin
                        n_elapsed = (|w_quo_nx[DVD_W-1:TS_W]) ? M48 : w_quo_nx[TS_W-1:0];
                        n_state   = S_UPD;
                    end
                end
            end
            S_UPD: begin
                w_rec_we      = 1'b1;
                w_rec_wd      = w_upd;
                n_rec         = w_upd;
                n_run[r_slot] = 1'b0;
                n_status      = ST_OK;
                n_state       = S_CUT;
            end
            S_CUT: begin
                n_cut = {2'b0, r_rec.min0} + {2'b0, r_rec.min1}
                      + {2'b0, r_rec.max0} + {2'b0, r_rec.max1};
                n_state = (r_rec.count == 32'd0) ? S_EMIT : S_TRIM;
            end
            S_TRIM: begin
                // drop the two smallest and the two largest once more than four calls exist
                if (r_rec.count > TRIM_LIMIT) begin
                    n_dvd = {w_trim[TS_W-1:0], 20'b0};
                    n_dvs = r_rec.count - TRIM_LIMIT;
                end else begin
                    n_dvd = {r_rec.total, 20'b0};
                    n_dvs = r_rec.count;
                end
                n_rem     = '0;
                n_quo     = '0;
                n_div_cnt = DIVC_W'(TS_W);
                n_div_avg = 1'b1;
                n_state   = S_DIV;
            end
            S_EMIT: begin
                if (!r_out_v || !i_out_stall) begin
                    n_out_v = 1'b1;
                    n_out.status = r_status;
                    if (r_empty) begin
                        n_out.elapsed_us    = '0;
                        n_out.call_count    = '0;
                        n_out.total_us      = '0;
                        n_out.min_us        = M48;
                        n_out.second_min_us = M48;
                        n_out.max_us        = '0;
                        n_out.second_max_us = '0;
                        n_out.average_us    = '0;
                        n_out.running       = 1'b0;
                    end else begin
                        n_out.elapsed_us    = r_elapsed;
                        n_out.call_count    = r_rec.count;
                        n_out.total_us      = r_rec.total;
                        n_out.min_us        = r_rec.min0;
                        n_out.second_min_us = r_rec.min1;
                        n_out.max_us        = r_rec.max0;
                        n_out.second_max_us = r_rec.max1;
                        n_out.average_us    = r_avg;
                        n_out.running       = r_run[r_slot];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_run   <= '0;
            r_freq  <= FREQ_RESET;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_run   <= n_run;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                r_freq <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_in      <= n_in;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_scan    <= n_scan;
        r_scan_v  <= n_scan_v;
        r_cmp_idx <= n_cmp_idx;
        r_rec     <= n_rec;
        r_status  <= n_status;
        r_empty   <= n_empty;
        r_elapsed <= n_elapsed;
        r_avg     <= n_avg;
        r_ticks   <= n_ticks;
        r_p_lo    <= n_p_lo;
        r_p_hi    <= n_p_hi;
        r_cut     <= n_cut;
        r_dvd     <= n_dvd;
        r_dvs     <= n_dvs;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div_cnt <= n_div_cnt;
        r_div_avg <= n_div_avg;
    end

    // tag store and slot record store, with registered reads
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            mem_tag[w_tag_wa] <= r_in.tag[TAG_BITS-1:0];
        end
        r_tag_q <= mem_tag[w_scan_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_rec_we) begin
            mem_rec[w_rec_wa] <= w_rec_wd;
        end
        r_rec_q <= mem_rec[r_slot];
    end

`ifndef NO_ASSERTIONS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SLOTS))
        else $error("slot fill count beyond table size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_data.kind == KIND_CLEAR)
        |=> (r_used == '0 && r_run == '0))
        else $error("clear did not empty the table");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt != '0))
        else $error("divider running with zero step count");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state == S_EMIT))
        else $error("result transfer raised outside emit");
`endif

endmodule
